[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, switched off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

[rtl/sps_pkg.sv]
// Types, codes and helper functions of the stepper phase sequencer.
package sps_pkg;

  // Command codes carried in the cmd field.
  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_START_CONT = 3'd1;
  localparam logic [2:0] CMD_STOP_CONT  = 3'd2;
  localparam logic [2:0] CMD_FIXED_MOVE = 3'd3;
  localparam logic [2:0] CMD_SINGLE     = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_STEP_PERIOD = 2'd0;
  localparam logic [1:0] CFG_PULSE_ON    = 2'd1;
  localparam logic [1:0] CFG_PULSE_OFF   = 2'd2;

  // Register reset values.
  localparam logic [8:0]  STEP_PERIOD_RST = 9'd100;
  localparam logic [15:0] PULSE_ON_RST    = 16'd50;
  localparam logic [15:0] PULSE_OFF_RST   = 16'd15;

  // Phase after reset.
  localparam logic [1:0] PHASE_RST = 2'd3;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_CONT  = 3'd1,
    MODE_FIXED = 3'd2,
    MODE_PON   = 3'd3,
    MODE_POFF  = 3'd4
  } sps_mode_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        direction;
    logic [15:0] count;
  } sps_in_t;

  typedef struct packed {
    logic       accepted;
    logic       coil_a_dir;
    logic       coil_b_dir;
    logic       coil_a_enable;
    logic       coil_b_enable;
    logic [1:0] phase;
    logic       running;
    logic       busy_res;
  } sps_out_t;

  typedef struct packed {
    logic [8:0]  step_period;
    logic [15:0] pulse_on_ticks;
    logic [15:0] pulse_off_ticks;
  } sps_cfg_t;

  // One step of the phase: forward increments, reverse decrements.
  function automatic logic [1:0] shift_phase(input logic [1:0] phase, input logic dir);
    shift_phase = dir ? phase - 2'd1 : phase + 2'd1;
  endfunction

  // Full-step direction levels {A, B} for a phase.
  function automatic logic [1:0] full_pattern(input logic [1:0] phase);
    full_pattern = {phase[1] ^ phase[0], ~phase[1]};
  endfunction

endpackage

[rtl/stepper_phase_sequencer.sv]
// Top level of the two-coil stepper phase sequencer.
//
// Items arrive on the in channel (in_valid, in_stall, in_item) as tick or
// command items and each gives exactly one result item on the out channel
// (out_valid, out_stall, out_item) with the coil levels, phase and status
// after that item. An item is taken at a clock edge where valid is high and
// stall is low.
// The item passes through the input register, where it is evaluated against
// the motion state, and then through the result register.
// Throughput is one item per cycle while the receiver does not stall, set by
// the combinational evaluation and state update between the two registers.
// When the receiver stalls, the result register holds its item; one more
// item may wait in the input register, after which in_stall rises.
// Reset (rst, synchronous) empties both registers, restores the register
// defaults (period 100, pulse on 50, pulse off 15) and sets phase 3 with
// both coils disabled. The configuration port (cfg_we, cfg_index,
// cfg_data) writes one register per cycle; the user must use it only while
// no item is in flight, as the block itself does not enforce this.
module stepper_phase_sequencer #(
  parameter int STEPS_PER_ROTATION = 200
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sps_pkg::sps_in_t   in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sps_pkg::sps_out_t  out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  sps_pkg::sps_cfg_t  cfg;
  sps_pkg::sps_in_t   in_q;
  sps_pkg::sps_out_t  result;
  logic               in_valid_q;
  logic               fire;

  // The held item is evaluated whenever the result register can take it.
  assign fire     = in_valid_q && (!out_valid || !out_stall);
  assign in_stall = in_valid_q && out_valid && out_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q <= in_item;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= result;
    end
  end

  sps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sps_core #(
    .STEPS_PER_ROTATION (STEPS_PER_ROTATION)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_q),
    .cfg    (cfg),
    .result (result)
  );

endmodule

[rtl/sps_cfg_regs.sv]
// Configuration register file of the stepper phase sequencer.
module sps_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output sps_pkg::sps_cfg_t   cfg
);

  // Write one register per enabled cycle; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_period     <= sps_pkg::STEP_PERIOD_RST;
      cfg.pulse_on_ticks  <= sps_pkg::PULSE_ON_RST;
      cfg.pulse_off_ticks <= sps_pkg::PULSE_OFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sps_pkg::CFG_STEP_PERIOD: cfg.step_period     <= cfg_data[8:0];
        sps_pkg::CFG_PULSE_ON:    cfg.pulse_on_ticks  <= cfg_data;
        sps_pkg::CFG_PULSE_OFF:   cfg.pulse_off_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/sps_core.sv]
// Motion state and combinational item evaluation of the stepper phase sequencer.
module sps_core #(
  parameter int STEPS_PER_ROTATION = 200
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  sps_pkg::sps_in_t   item,
  input  sps_pkg::sps_cfg_t  cfg,
  output sps_pkg::sps_out_t  result
);

  localparam int SIR_W = $clog2(STEPS_PER_ROTATION + 1);
  localparam logic [SIR_W:0] SPR = (SIR_W + 1)'(STEPS_PER_ROTATION);

  sps_pkg::sps_mode_t mode, mode_next;
  logic [1:0]       phase, phase_next;
  logic             prev_dir, prev_dir_next;
  logic             run_flag, run_flag_next;
  logic             run_dir, run_dir_next;
  logic [15:0]      rotations_left, rotations_left_next;
  logic [SIR_W-1:0] steps_in_rot, steps_in_rot_next;
  logic [15:0]      moves_left, moves_left_next;
  logic [15:0]      tick_count, tick_count_next;
  logic             a_dir, a_dir_next;
  logic             b_dir, b_dir_next;
  logic             a_en, a_en_next;
  logic             b_en, b_en_next;

  logic             accepted;
  logic             busy;
  logic [16:0]      tick_inc;
  logic [8:0]       period_eff;
  logic [SIR_W:0]   sir_inc;
  logic [1:0]       step_phase;
  logic [1:0]       pat;

  // State registers, loaded when an item is evaluated.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= sps_pkg::MODE_IDLE;
      phase          <= sps_pkg::PHASE_RST;
      prev_dir       <= 1'b0;
      run_flag       <= 1'b0;
      run_dir        <= 1'b0;
      rotations_left <= '0;
      steps_in_rot   <= '0;
      moves_left     <= '0;
      tick_count     <= '0;
      a_dir          <= 1'b0;
      b_dir          <= 1'b0;
      a_en           <= 1'b0;
      b_en           <= 1'b0;
    end else if (fire) begin
      mode           <= mode_next;
      phase          <= phase_next;
      prev_dir       <= prev_dir_next;
      run_flag       <= run_flag_next;
      run_dir        <= run_dir_next;
      rotations_left <= rotations_left_next;
      steps_in_rot   <= steps_in_rot_next;
      moves_left     <= moves_left_next;
      tick_count     <= tick_count_next;
      a_dir          <= a_dir_next;
      b_dir          <= b_dir_next;
      a_en           <= a_en_next;
      b_en           <= b_en_next;
    end
  end

  // Shared terms: busy flag, incremented tick, effective period, incremented
  // step count within the rotation and the phase that a starting step would move to.
  always_comb begin
    busy       = (mode != sps_pkg::MODE_IDLE);
    tick_inc   = {1'b0, tick_count} + 17'd1;
    period_eff = (cfg.step_period == 9'd0) ? 9'd1 : cfg.step_period;
    sir_inc    = {1'b0, steps_in_rot} + {{SIR_W{1'b0}}, 1'b1};
    step_phase = (item.direction == prev_dir) ? sps_pkg::shift_phase(phase, item.direction)
                                              : phase;
  end

  // Next state and result of the item in the input register.
  always_comb begin
    mode_next           = mode;
    phase_next          = phase;
    prev_dir_next       = prev_dir;
    run_flag_next       = run_flag;
    run_dir_next        = run_dir;
    rotations_left_next = rotations_left;
    steps_in_rot_next   = steps_in_rot;
    moves_left_next     = moves_left;
    tick_count_next     = tick_count;
    a_dir_next          = a_dir;
    b_dir_next          = b_dir;
    a_en_next           = a_en;
    b_en_next           = b_en;
    accepted            = 1'b1;
    pat                 = sps_pkg::full_pattern(phase);

    unique case (item.cmd)
      sps_pkg::CMD_TICK: begin
        unique case (mode)
          sps_pkg::MODE_CONT: begin
            if (tick_inc < {8'd0, period_eff}) begin
              tick_count_next = tick_inc[15:0];
            end else begin
              tick_count_next = '0;
              if (!run_flag) begin
                mode_next = sps_pkg::MODE_IDLE;
                a_en_next = 1'b0;
                b_en_next = 1'b0;
              end
              phase_next = sps_pkg::shift_phase(phase, run_dir);
              pat        = sps_pkg::full_pattern(phase_next);
              a_dir_next = pat[1];
              b_dir_next = pat[0];
              // Count the step towards a full rotation.
              if (rotations_left != 16'd0) begin
                if (sir_inc >= SPR) begin
                  steps_in_rot_next   = '0;
                  rotations_left_next = rotations_left - 16'd1;
                  if (rotations_left == 16'd1) begin
                    run_flag_next = 1'b0;
                  end
                end else begin
                  steps_in_rot_next = sir_inc[SIR_W-1:0];
                end
              end
            end
          end
          sps_pkg::MODE_FIXED: begin
            if (tick_inc < {8'd0, period_eff}) begin
              tick_count_next = tick_inc[15:0];
            end else begin
              tick_count_next = '0;
              if (moves_left == 16'd0) begin
                a_en_next = 1'b0;
                b_en_next = 1'b0;
                mode_next = sps_pkg::MODE_IDLE;
              end else begin
                phase_next      = sps_pkg::shift_phase(phase, prev_dir);
                pat             = sps_pkg::full_pattern(phase_next);
                a_dir_next      = pat[1];
                b_dir_next      = pat[0];
                moves_left_next = moves_left - 16'd1;
              end
            end
          end
          sps_pkg::MODE_PON: begin
            if (tick_inc < {1'b0, cfg.pulse_on_ticks}) begin
              tick_count_next = tick_inc[15:0];
            end else begin
              tick_count_next = '0;
              a_en_next = 1'b0;
              b_en_next = 1'b0;
              mode_next = (cfg.pulse_off_ticks == 16'd0) ? sps_pkg::MODE_IDLE
                                                          : sps_pkg::MODE_POFF;
            end
          end
          sps_pkg::MODE_POFF: begin
            if (tick_inc >= {1'b0, cfg.pulse_off_ticks}) begin
              tick_count_next = '0;
              mode_next       = sps_pkg::MODE_IDLE;
            end else begin
              tick_count_next = tick_inc[15:0];
            end
          end
          default: ;
        endcase
      end
      sps_pkg::CMD_START_CONT: begin
        if (busy && mode != sps_pkg::MODE_CONT) begin
          accepted = 1'b0;
        end else begin
          run_dir_next        = item.direction;
          run_flag_next       = 1'b1;
          rotations_left_next = item.count;
          steps_in_rot_next   = '0;
          a_en_next           = 1'b1;
          b_en_next           = 1'b1;
          phase_next          = step_phase;
          prev_dir_next       = item.direction;
          pat                 = sps_pkg::full_pattern(step_phase);
          a_dir_next          = pat[1];
          b_dir_next          = pat[0];
          tick_count_next     = '0;
          mode_next           = sps_pkg::MODE_CONT;
        end
      end
      sps_pkg::CMD_STOP_CONT: begin
        run_flag_next = 1'b0;
      end
      sps_pkg::CMD_FIXED_MOVE: begin
        if (busy) begin
          accepted = 1'b0;
        end else if (item.count != 16'd0) begin
          a_en_next       = 1'b1;
          b_en_next       = 1'b1;
          phase_next      = step_phase;
          prev_dir_next   = item.direction;
          pat             = sps_pkg::full_pattern(step_phase);
          a_dir_next      = pat[1];
          b_dir_next      = pat[0];
          tick_count_next = '0;
          moves_left_next = item.count - 16'd1;
          mode_next       = sps_pkg::MODE_FIXED;
        end
      end
      sps_pkg::CMD_SINGLE: begin
        if (busy) begin
          accepted = 1'b0;
        end else begin
          // Wave drive: one coil energised, its level set by the new phase.
          phase_next = sps_pkg::shift_phase(phase, item.direction);
          unique case (phase_next)
            2'd0: begin
              a_dir_next = 1'b1;
              a_en_next  = 1'b1;
              b_en_next  = 1'b0;
            end
            2'd1: begin
              b_dir_next = 1'b0;
              a_en_next  = 1'b0;
              b_en_next  = 1'b1;
            end
            2'd2: begin
              a_dir_next = 1'b0;
              a_en_next  = 1'b1;
              b_en_next  = 1'b0;
            end
            default: begin
              b_dir_next = 1'b1;
              a_en_next  = 1'b0;
              b_en_next  = 1'b1;
            end
          endcase
          tick_count_next = '0;
          mode_next       = sps_pkg::MODE_PON;
        end
      end
      default: begin
        accepted = 1'b0;
      end
    endcase

    result.accepted      = accepted;
    result.coil_a_dir    = a_dir_next;
    result.coil_b_dir    = b_dir_next;
    result.coil_a_enable = a_en_next;
    result.coil_b_enable = b_en_next;
    result.phase         = phase_next;
    result.running       = run_flag_next;
    result.busy_res      = (mode_next != sps_pkg::MODE_IDLE);
  end

endmodule

[rtl/sps_checker.sv]
// Port-level checker of the stepper phase sequencer and its bind.
`include "assert_macros.svh"

module sps_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input sps_pkg::sps_out_t  out_item
);

  // A stalled result item stays and holds its value.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_item))

  // Reset empties the result register.
  `ASSERT_NEXT_ALWAYS(a_rst_empty, clk, rst, !out_valid)

  // Continuous running is always a motion in progress.
  `ASSERT_IMPLIES(a_run_busy, clk, rst, out_valid && out_item.running, out_item.busy_res)

  // With no motion in progress both coil drivers are off.
  `ASSERT_IMPLIES(a_idle_off, clk, rst, out_valid && !out_item.busy_res, !out_item.coil_a_enable && !out_item.coil_b_enable)

  // With both coils enabled the levels follow the full-step pattern of the phase.
  `ASSERT_IMPLIES(a_full_pat, clk, rst, out_valid && out_item.coil_a_enable && out_item.coil_b_enable, (out_item.coil_a_dir == (out_item.phase[1] ^ out_item.phase[0])) && (out_item.coil_b_dir == !out_item.phase[1]))

endmodule

bind stepper_phase_sequencer sps_checker u_sps_checker (.*);

[tb/stepper_phase_sequencer_test.sv]
// Self-checking testbench of the stepper phase sequencer: a directed table, then random items.
module stepper_phase_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS_PER_REV = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int HOLD_OFF_AT = 300;
  localparam int PHASES = 14;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int SPIN_TICKS = 410;
  localparam int MAX_REPORTS = 10;

  // Command codes the block does not know.
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  localparam sps_pkg::sps_out_t AT_REST = '{accepted: 1'b1, coil_a_dir: 1'b0,
                                            coil_b_dir: 1'b0, coil_a_enable: 1'b0,
                                            coil_b_enable: 1'b0,
                                            phase: sps_pkg::PHASE_RST, running: 1'b0,
                                            busy_res: 1'b0};
  localparam sps_pkg::sps_out_t REFUSED_AT_REST = '{accepted: 1'b0, coil_a_dir: 1'b0,
                                                    coil_b_dir: 1'b0, coil_a_enable: 1'b0,
                                                    coil_b_enable: 1'b0,
                                                    phase: sps_pkg::PHASE_RST,
                                                    running: 1'b0, busy_res: 1'b0};
  localparam sps_pkg::sps_out_t UNTYPED = '0;
  localparam sps_pkg::sps_in_t TICK_ITEM = '{sps_pkg::CMD_TICK, 1'b0, 16'h0000};

  typedef struct {
    logic              is_cfg;
    logic [1:0]        reg_idx;
    logic [15:0]       reg_val;
    sps_pkg::sps_in_t  it;
    logic              typed;
    sps_pkg::sps_out_t want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  sps_pkg::sps_in_t  in_item = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  sps_pkg::sps_out_t out_item;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [15:0]       cfg_data = '0;

  // Testbench state shared between the processes.
  sps_pkg::sps_out_t pending_coils [$];
  sps_pkg::sps_out_t predicted_coils;
  sps_pkg::sps_out_t oldest_coils;
  sps_pkg::sps_out_t typed_coils = '0;
  logic     want_typed = 1'b0;
  logic     calm = 1'b0;
  logic     held_once = 1'b0;
  int       mismatches = 0;
  int       results_seen = 0;
  int       quiet_cycles = 0;

  // Copy of the registers and motion state as the block should hold them.
  logic [8:0]         period_reg;
  logic [15:0]        on_reg;
  logic [15:0]        off_reg;
  logic [1:0]         phase_q;
  logic               last_dir;
  sps_pkg::sps_mode_t mode_q;
  logic               run_q;
  logic               run_dir_q;
  logic [15:0]        rotations_q;
  logic [7:0]         rev_steps_q;
  logic [15:0]        moves_q;
  logic [15:0]        ticks_q;
  logic               a_dir_q, b_dir_q, a_en_q, b_en_q;

  // Directed stimulus: extremes, every command, zero lengths and refusals.
  plan_row_t plan [0:27] = '{
    // Straight after reset a tick leaves phase 3 with both coils off.
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, TICK_ITEM, 1'b1, AT_REST},
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, '{CMD_UNUSED_LO, 1'b1, 16'hFFFF}, 1'b1,
      REFUSED_AT_REST},
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, '{CMD_UNUSED_HI, 1'b0, 16'h0000}, 1'b1,
      REFUSED_AT_REST},
    // A stop is always taken, and a move of no steps is taken and does nothing.
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, '{sps_pkg::CMD_STOP_CONT, 1'b1, 16'hFFFF},
      1'b1, AT_REST},
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, '{sps_pkg::CMD_FIXED_MOVE, 1'b1, 16'h0000},
      1'b1, AT_REST},
    // Zero period and zero pulse lengths.
    '{1'b1, sps_pkg::CFG_STEP_PERIOD, 16'h0000, TICK_ITEM, 1'b0, UNTYPED},
    '{1'b1, sps_pkg::CFG_PULSE_ON, 16'h0000, TICK_ITEM, 1'b0, UNTYPED},
    '{1'b1, sps_pkg::CFG_PULSE_OFF, 16'h0000, TICK_ITEM, 1'b0, UNTYPED},
    // A reversed fixed move, with commands refused while it runs.
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, '{sps_pkg::CMD_FIXED_MOVE, 1'b1, 16'd2},
      1'b0, UNTYPED},
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, '{sps_pkg::CMD_SINGLE, 1'b0, 16'h0000},
      1'b0, UNTYPED},
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, '{sps_pkg::CMD_FIXED_MOVE, 1'b0, 16'd3},
      1'b0, UNTYPED},
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, TICK_ITEM, 1'b0, UNTYPED},
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, TICK_ITEM, 1'b0, UNTYPED},
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, TICK_ITEM, 1'b0, UNTYPED},
    // A single pulse refuses a continuous start until it has ended.
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, '{sps_pkg::CMD_SINGLE, 1'b0, 16'h0000},
      1'b0, UNTYPED},
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, '{sps_pkg::CMD_START_CONT, 1'b0, 16'd1},
      1'b0, UNTYPED},
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, TICK_ITEM, 1'b0, UNTYPED},
    // Continuous run, restarted while running, then stopped.
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, '{sps_pkg::CMD_START_CONT, 1'b1, 16'd1},
      1'b0, UNTYPED},
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, '{sps_pkg::CMD_START_CONT, 1'b0, 16'd0},
      1'b0, UNTYPED},
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, TICK_ITEM, 1'b0, UNTYPED},
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, '{sps_pkg::CMD_STOP_CONT, 1'b0, 16'h0000},
      1'b0, UNTYPED},
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, TICK_ITEM, 1'b0, UNTYPED},
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, TICK_ITEM, 1'b0, UNTYPED},
    // Largest register values, then a pulse that the next phase cuts short.
    '{1'b1, sps_pkg::CFG_STEP_PERIOD, 16'd511, TICK_ITEM, 1'b0, UNTYPED},
    '{1'b1, sps_pkg::CFG_PULSE_ON, 16'hFFFF, TICK_ITEM, 1'b0, UNTYPED},
    '{1'b1, sps_pkg::CFG_PULSE_OFF, 16'hFFFF, TICK_ITEM, 1'b0, UNTYPED},
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, '{sps_pkg::CMD_SINGLE, 1'b1, 16'hFFFF},
      1'b0, UNTYPED},
    '{1'b0, sps_pkg::CFG_STEP_PERIOD, 16'h0000, TICK_ITEM, 1'b0, UNTYPED}
  };

  stepper_phase_sequencer #(
    .STEPS_PER_ROTATION(STEPS_PER_REV)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // One full step of the phase in the given direction.
  function automatic void turn(input logic dir);
    phase_q = dir ? phase_q + 2'd3 : phase_q + 2'd1;
  endfunction

  // Drive the full-step direction levels of the current phase.
  function automatic void show_full_step();
    case (phase_q)
      2'd0: {a_dir_q, b_dir_q} = 2'b01;
      2'd1: {a_dir_q, b_dir_q} = 2'b11;
      2'd2: {a_dir_q, b_dir_q} = 2'b10;
      default: {a_dir_q, b_dir_q} = 2'b00;
    endcase
  endfunction

  function automatic logic [8:0] active_period();
    return (period_reg == 9'd0) ? 9'd1 : period_reg;
  endfunction

  // First step of a run or a fixed move: the shift is skipped on a reversal.
  function automatic void begin_motion(input logic dir);
    a_en_q = 1'b1;
    b_en_q = 1'b1;
    if (dir == last_dir) begin
      turn(dir);
    end
    last_dir = dir;
    show_full_step();
    ticks_q = '0;
  endfunction

  // Wave-drive pulse: only one coil is energised, the other direction level is kept.
  function automatic void wave_pulse(input logic dir);
    turn(dir);
    case (phase_q)
      2'd0: begin
        a_dir_q = 1'b1;
        a_en_q = 1'b1;
        b_en_q = 1'b0;
      end
      2'd1: begin
        b_dir_q = 1'b0;
        b_en_q = 1'b1;
        a_en_q = 1'b0;
      end
      2'd2: begin
        a_dir_q = 1'b0;
        a_en_q = 1'b1;
        b_en_q = 1'b0;
      end
      default: begin
        b_dir_q = 1'b1;
        b_en_q = 1'b1;
        a_en_q = 1'b0;
      end
    endcase
    ticks_q = '0;
    mode_q = sps_pkg::MODE_PON;
  endfunction

  // Advance the motion in progress by one tick.
  function automatic void tick_motion();
    case (mode_q)
      sps_pkg::MODE_CONT: begin
        ticks_q = ticks_q + 16'd1;
        if (ticks_q >= active_period()) begin
          ticks_q = '0;
          // With the run flag already clear this is the final step.
          if (!run_q) begin
            mode_q = sps_pkg::MODE_IDLE;
            a_en_q = 1'b0;
            b_en_q = 1'b0;
          end
          turn(run_dir_q);
          show_full_step();
          if (rotations_q != 16'd0) begin
            rev_steps_q = rev_steps_q + 8'd1;
            if (rev_steps_q >= STEPS_PER_REV) begin
              rev_steps_q = '0;
              rotations_q = rotations_q - 16'd1;
              if (rotations_q == 16'd0) begin
                run_q = 1'b0;
              end
            end
          end
        end
      end
      sps_pkg::MODE_FIXED: begin
        ticks_q = ticks_q + 16'd1;
        if (ticks_q >= active_period()) begin
          ticks_q = '0;
          if (moves_q == 16'd0) begin
            a_en_q = 1'b0;
            b_en_q = 1'b0;
            mode_q = sps_pkg::MODE_IDLE;
          end else begin
            turn(last_dir);
            show_full_step();
            moves_q = moves_q - 16'd1;
          end
        end
      end
      sps_pkg::MODE_PON: begin
        ticks_q = ticks_q + 16'd1;
        if (ticks_q >= on_reg) begin
          ticks_q = '0;
          a_en_q = 1'b0;
          b_en_q = 1'b0;
          mode_q = (off_reg == 16'd0) ? sps_pkg::MODE_IDLE : sps_pkg::MODE_POFF;
        end
      end
      sps_pkg::MODE_POFF: begin
        ticks_q = ticks_q + 16'd1;
        if (ticks_q >= off_reg) begin
          ticks_q = '0;
          mode_q = sps_pkg::MODE_IDLE;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Apply one item to the copied state and return the coil outputs it leaves.
  function automatic sps_pkg::sps_out_t coil_outcome(input sps_pkg::sps_in_t it);
    sps_pkg::sps_out_t r;
    logic     busy;
    logic     took;
    busy = (mode_q != sps_pkg::MODE_IDLE);
    took = 1'b1;
    case (it.cmd)
      sps_pkg::CMD_TICK: tick_motion();
      sps_pkg::CMD_START_CONT: begin
        if (busy && mode_q != sps_pkg::MODE_CONT) begin
          took = 1'b0;
        end else begin
          run_dir_q = it.direction;
          run_q = 1'b1;
          rotations_q = it.count;
          rev_steps_q = '0;
          begin_motion(it.direction);
          mode_q = sps_pkg::MODE_CONT;
        end
      end
      sps_pkg::CMD_STOP_CONT: run_q = 1'b0;
      sps_pkg::CMD_FIXED_MOVE: begin
        if (busy) begin
          took = 1'b0;
        end else if (it.count != 16'd0) begin
          begin_motion(it.direction);
          moves_q = it.count - 16'd1;
          mode_q = sps_pkg::MODE_FIXED;
        end
      end
      sps_pkg::CMD_SINGLE: begin
        if (busy) begin
          took = 1'b0;
        end else begin
          wave_pulse(it.direction);
        end
      end
      default: took = 1'b0;
    endcase
    r.accepted = took;
    r.coil_a_dir = a_dir_q;
    r.coil_b_dir = b_dir_q;
    r.coil_a_enable = a_en_q;
    r.coil_b_enable = b_en_q;
    r.phase = phase_q;
    r.running = run_q;
    r.busy_res = (mode_q != sps_pkg::MODE_IDLE);
    return r;
  endfunction

  task automatic reset_model();
    period_reg = sps_pkg::STEP_PERIOD_RST;
    on_reg = sps_pkg::PULSE_ON_RST;
    off_reg = sps_pkg::PULSE_OFF_RST;
    phase_q = sps_pkg::PHASE_RST;
    last_dir = 1'b0;
    mode_q = sps_pkg::MODE_IDLE;
    run_q = 1'b0;
    run_dir_q = 1'b0;
    rotations_q = '0;
    rev_steps_q = '0;
    moves_q = '0;
    ticks_q = '0;
    {a_dir_q, b_dir_q, a_en_q, b_en_q} = 4'b0000;
  endtask

  function automatic string coil_text(input sps_pkg::sps_out_t c);
    return $sformatf("acc %b dir %b%b en %b%b phase %0d run %b busy %b", c.accepted,
                     c.coil_a_dir, c.coil_b_dir, c.coil_a_enable, c.coil_b_enable,
                     c.phase, c.running, c.busy_res);
  endfunction

  task automatic record_failure(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  // Draw a random command item; fixed moves and most continuous starts get short counts.
  function automatic sps_pkg::sps_in_t draw_command();
    sps_pkg::sps_in_t it;
    int      roll;
    roll = $urandom_range(99, 0);
    it.direction = 1'($urandom_range(1, 0));
    it.count = 16'($urandom_range(16'hFFFF, 0));
    if (roll < 62) begin
      it.cmd = sps_pkg::CMD_TICK;
    end else if (roll < 72) begin
      it.cmd = sps_pkg::CMD_START_CONT;
      if ($urandom_range(9, 0) != 0) begin
        it.count = 16'($urandom_range(2, 0));
      end
    end else if (roll < 78) begin
      it.cmd = sps_pkg::CMD_STOP_CONT;
    end else if (roll < 88) begin
      it.cmd = sps_pkg::CMD_FIXED_MOVE;
      it.count = 16'($urandom_range(6, 0));
    end else if (roll < 96) begin
      it.cmd = sps_pkg::CMD_SINGLE;
    end else begin
      it.cmd = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
    end
    return it;
  endfunction

  // Register write, only once every item in flight has come out.
  task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
    in_valid <= 1'b0;
    while (pending_coils.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sps_pkg::CFG_STEP_PERIOD: period_reg = val[8:0];
      sps_pkg::CFG_PULSE_ON: on_reg = val;
      sps_pkg::CFG_PULSE_OFF: off_reg = val;
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  task automatic set_all_regs(input logic [15:0] per, input logic [15:0] on_t,
                              input logic [15:0] off_t);
    set_reg(sps_pkg::CFG_STEP_PERIOD, per);
    set_reg(sps_pkg::CFG_PULSE_ON, on_t);
    set_reg(sps_pkg::CFG_PULSE_OFF, off_t);
  endtask

  // Offer one item after a random gap and hold it until it is taken.
  task automatic offer_item(input sps_pkg::sps_in_t it, input logic typed,
                            input sps_pkg::sps_out_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(11, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    want_typed = typed;
    typed_coils = want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic offer_tick();
    sps_pkg::sps_in_t it;
    it = TICK_ITEM;
    it.direction = 1'($urandom_range(1, 0));
    it.count = 16'($urandom_range(16'hFFFF, 0));
    offer_item(it, 1'b0, UNTYPED);
  endtask

  // Prediction on every accepted item, checking on every accepted result.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predicted_coils = coil_outcome(in_item);
        pending_coils.push_back(want_typed ? typed_coils : predicted_coils);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_coils.size() == 0) begin
          record_failure($sformatf("unexpected result: %s", coil_text(out_item)));
        end else begin
          oldest_coils = pending_coils.pop_front();
          if (out_item.accepted !== oldest_coils.accepted ||
              out_item.coil_a_dir !== oldest_coils.coil_a_dir ||
              out_item.coil_b_dir !== oldest_coils.coil_b_dir ||
              out_item.coil_a_enable !== oldest_coils.coil_a_enable ||
              out_item.coil_b_enable !== oldest_coils.coil_b_enable ||
              out_item.phase !== oldest_coils.phase ||
              out_item.running !== oldest_coils.running ||
              out_item.busy_res !== oldest_coils.busy_res) begin
            record_failure($sformatf("mismatch: expected %s, got %s",
                                     coil_text(oldest_coils), coil_text(out_item)));
          end
        end
      end
      // Watchdog on cycles in which neither side moves an item.
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that fills the block.
  initial begin : result_sink
    int hold;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(11, 0);
      if (!held_once && results_seen >= HOLD_OFF_AT) begin
        hold += HOLD_OFF_CYCLES;
        held_once = 1'b1;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Stimulus: reset, directed table, random phases, then the end of the run.
  initial begin : stimulus
    sps_pkg::sps_in_t it;
    int      p;
    logic    spin;
    reset_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        set_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        offer_item(plan[i].it, plan[i].typed, plan[i].want);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      calm = (p % 4 == 1);
      spin = (p % 6 == 3);
      // Each phase starts with new register values; motion may still be under way.
      if (spin) begin
        set_all_regs(16'd1, 16'd1, 16'd0);
      end else if (p == 0) begin
        set_all_regs(16'd1, 16'd1, 16'd0);
      end else if (p == 1) begin
        set_all_regs(16'd256, 16'hFFFF, 16'hFFFF);
      end else if (p == 2) begin
        set_all_regs(16'd2, 16'd3, 16'd1);
      end else begin
        set_all_regs(16'(($urandom_range(7, 0) == 0) ? $urandom_range(511, 0)
                                                     : $urandom_range(6, 1)),
                     16'($urandom_range(8, 0)), 16'($urandom_range(8, 0)));
      end
      if (spin) begin
        // Whole rotations at the shortest period, up to the final step.
        repeat (3) offer_tick();
        it = '{sps_pkg::CMD_START_CONT, 1'b0, 16'd1};
        it.direction = 1'($urandom_range(1, 0));
        it.count = 16'($urandom_range(2, 1));
        offer_item(it, 1'b0, UNTYPED);
        repeat (SPIN_TICKS) offer_tick();
      end else begin
        repeat (ITEMS_PER_PHASE) offer_item(draw_command(), 1'b0, UNTYPED);
      end
    end

    // A fixed move of the largest step count once everything has settled.
    calm = 1'b0;
    set_all_regs(16'd1, 16'd1, 16'd0);
    offer_item('{sps_pkg::CMD_STOP_CONT, 1'b0, 16'h0000}, 1'b0, UNTYPED);
    repeat (8) offer_tick();
    it = '{sps_pkg::CMD_FIXED_MOVE, 1'b0, 16'hFFFF};
    it.direction = 1'($urandom_range(1, 0));
    offer_item(it, 1'b0, UNTYPED);
    repeat (10) offer_tick();

    in_valid <= 1'b0;
    while (pending_coils.size() != 0) @(negedge clk);
    repeat (2 * DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_coils.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[stepper_phase_sequencer.f]
+incdir+rtl
rtl/sps_pkg.sv
rtl/sps_cfg_regs.sv
rtl/sps_core.sv
rtl/stepper_phase_sequencer.sv
rtl/sps_checker.sv
tb/stepper_phase_sequencer_test.sv
